// ----- rtl/core/frt_pkg.sv -----
// ----------------------------------------------------------------------------
// frt_pkg
// Types, codes and constants shared by the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned SlotsDefault  = 8;
  localparam int unsigned SlotsMax      = 8;
  localparam logic [15:0] ExpiryReset   = 16'd1000;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_COMPLETED = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_FULL      = 3'd4,
    ST_TICK      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_OUT
  } fsm_e;

  typedef struct packed {
    logic        kind;
    logic [47:0] src_mac;
    logic [15:0] msg_id;
    logic [7:0]  frag_index;
    logic [7:0]  frag_len;
    logic [7:0]  msg_type;
    logic [15:0] total_size;
  } frag_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  slot;
    logic [15:0] write_offset;
    logic [7:0]  copy_len;
    logic [7:0]  done_type;
    logic [15:0] done_size;
    logic [7:0]  expired_mask;
  } frag_out_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // register the incoming transaction and run the match
    logic execute;  // update the table and build the result
  } dp_cmd_t;

endpackage

// ----- rtl/core/frt_ctrl.sv -----
// ----------------------------------------------------------------------------
// frt_ctrl
// Sequencer: capture, execute, hold the result until taken.
// ----------------------------------------------------------------------------
module frt_ctrl
  import frt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d = FSM_OUT;
      end
      FSM_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          // accept the next transaction while this one leaves
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d = FSM_EXEC;
          end else begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/frt_dp.sv -----
// ----------------------------------------------------------------------------
// frt_dp
// Slot table, match logic, time counter and result register.
// ----------------------------------------------------------------------------
module frt_dp
  import frt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  frag_in_t    in_i,
  input  logic [15:0] expiry_i,
  output frag_out_t   out_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] busy_q;
  logic [47:0] src_q   [SLOTS];
  logic [15:0] id_q    [SLOTS];
  logic [7:0]  last_q  [SLOTS];
  logic [15:0] fill_q  [SLOTS];
  logic [15:0] total_q [SLOTS];
  logic [7:0]  type_q  [SLOTS];
  logic [31:0] stamp_q [SLOTS];
  logic [31:0] now_q;

  frag_in_t         req_q;
  logic [SLOTS-1:0] hit_q;
  logic [SLOTS-1:0] idle_q;
  frag_out_t        out_q, out_d;

  // match and expiry vectors, registered at capture
  logic [SLOTS-1:0] hit_d, idle_d;
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit_d[s] = busy_q[s] && src_q[s] == in_i.src_mac && id_q[s] == in_i.msg_id &&
                 ({1'b0, in_i.frag_index} == {1'b0, last_q[s]} + 9'd1);
      idle_d[s] = busy_q[s] &&
                  ((now_q + 32'd1 - stamp_q[s]) >= {16'd0, expiry_i});
    end
  end

  // lowest hit and lowest free slot
  logic          any_hit, any_free;
  logic [SW-1:0] hit_s, free_s;
  always_comb begin
    any_hit  = 1'b0;
    any_free = 1'b0;
    hit_s    = '0;
    free_s   = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (hit_q[s]) begin
        any_hit = 1'b1;
        hit_s   = SW'(s);
      end
      if (!busy_q[s]) begin
        any_free = 1'b1;
        free_s   = SW'(s);
      end
    end
  end

  logic [15:0] room, copy_a, fill_new, copy_n;
  always_comb begin
    room     = total_q[hit_s] - fill_q[hit_s];
    copy_a   = ({8'd0, req_q.frag_len} < room) ? {8'd0, req_q.frag_len} : room;
    fill_new = fill_q[hit_s] + copy_a;
    copy_n   = ({8'd0, req_q.frag_len} < req_q.total_size) ?
               {8'd0, req_q.frag_len} : req_q.total_size;
  end

  // result of the captured transaction
  always_comb begin
    out_d = '0;
    if (req_q.kind) begin
      out_d.status       = ST_TICK;
      out_d.expired_mask = 8'(idle_q);
    end else if (any_hit) begin
      out_d.slot         = 3'(hit_s);
      out_d.write_offset = fill_q[hit_s];
      out_d.copy_len     = copy_a[7:0];
      if (fill_new >= total_q[hit_s]) begin
        out_d.status    = ST_COMPLETED;
        out_d.done_type = type_q[hit_s];
        out_d.done_size = total_q[hit_s];
      end else begin
        out_d.status = ST_APPENDED;
      end
    end else if (req_q.frag_index != 8'd0) begin
      out_d.status = ST_IGNORED;
    end else if (!any_free) begin
      out_d.status = ST_FULL;
    end else begin
      out_d.slot     = 3'(free_s);
      out_d.copy_len = copy_n[7:0];
      if (copy_n >= req_q.total_size) begin
        out_d.status    = ST_COMPLETED;
        out_d.done_type = req_q.msg_type;
        out_d.done_size = req_q.total_size;
      end else begin
        out_d.status = ST_STARTED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      now_q  <= '0;
    end else if (cmd_i.execute) begin
      if (req_q.kind) begin
        now_q  <= now_q + 32'd1;
        busy_q <= busy_q & ~idle_q;
      end else if (any_hit) begin
        if (fill_new >= total_q[hit_s]) busy_q[hit_s] <= 1'b0;
      end else if (req_q.frag_index == 8'd0 && any_free && copy_n < req_q.total_size) begin
        busy_q[free_s] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= in_i;
      hit_q  <= hit_d;
      idle_q <= idle_d;
    end
    if (cmd_i.execute) begin
      out_q <= out_d;
      if (!req_q.kind) begin
        if (any_hit) begin
          fill_q[hit_s]  <= fill_new;
          last_q[hit_s]  <= req_q.frag_index;
          stamp_q[hit_s] <= now_q;
        end else if (req_q.frag_index == 8'd0 && any_free &&
                     copy_n < req_q.total_size) begin
          src_q[free_s]   <= req_q.src_mac;
          id_q[free_s]    <= req_q.msg_id;
          last_q[free_s]  <= 8'd0;
          fill_q[free_s]  <= copy_n;
          total_q[free_s] <= req_q.total_size;
          type_q[free_s]  <= req_q.msg_type;
          stamp_q[free_s] <= now_q;
        end
      end
    end
  end

  assign out_o = out_q;

endmodule

// ----- rtl/core/fragment_reassembly_tracker_top.sv -----
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker_top
// Slot table that tracks partly received fragmented messages.
// ----------------------------------------------------------------------------
// Each transaction is captured and compared against all slots in parallel
// (source, id, next index, idle time), then the slot table is updated and
// the result registered. The result register holds until taken; the next
// transaction is accepted in the cycle the result leaves, not earlier. A tick
// advances the millisecond counter and frees idle slots, reporting them in
// expired_mask. expiry_ms is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, the block itself does not enforce this.
module fragment_reassembly_tracker_top
  import frt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  frag_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output frag_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] expiry_q;
  dp_cmd_t     cmd;

  // hold the expiry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= ExpiryReset;
    end else if (cfg_we_i) begin
      expiry_q <= cfg_wdata_i;
    end
  end

  frt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .cmd_o (cmd)
  );

  frt_dp #(.SLOTS(SLOTS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .in_i     (in_data_i),
    .expiry_i (expiry_q),
    .out_o    (out_data_o)
  );

endmodule

// ----- rtl/core/frt_checker.sv -----
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks on the tracker.
// ----------------------------------------------------------------------------
module frt_checker
  import frt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input frag_out_t out_data_o
);

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o ##1 out_valid_o)
    else $error("result not presented two cycles after accept");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  a_tick_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_TICK) |-> out_data_o.expired_mask == 8'd0)
    else $error("mask outside tick");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("accept while result stalled");

endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

// ----- test/tb_fragment_reassembly_tracker_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fragment_reassembly_tracker_top
// Self-checking bench for the fragment reassembly tracker. A queue of
// fragments and ticks feeds a clocked driver, a slot-table tracker inside
// the bench predicts every result, and a clocked monitor compares each
// returned transaction field by field. Both sides idle at random, the
// receiver holds off once for a long stretch, and expiry_ms is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_fragment_reassembly_tracker_top;
  import frt_pkg::*;

  localparam int unsigned NSLOT      = 8;
  localparam int unsigned STALL_MAX  = 2000;  // idle cycles before the watchdog fires
  localparam int unsigned NSTREAM    = 4;
  localparam int unsigned HOLD_START = 2500;  // cycle after reset of the long hold-off
  localparam int unsigned HOLD_LEN   = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  frag_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  frag_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  fragment_reassembly_tracker_top #(.SLOTS(NSLOT)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Bench copy of the slot table
  // --------------------------------------------------------------------------
  logic        busy_q   [NSLOT];
  logic [47:0] source_q [NSLOT];
  logic [15:0] ident_q  [NSLOT];
  logic [7:0]  last_q   [NSLOT];
  logic [15:0] filled_q [NSLOT];
  logic [15:0] total_q  [NSLOT];
  logic [7:0]  mtype_q  [NSLOT];
  logic [31:0] stamp_q  [NSLOT];
  logic [31:0] clock_ms = '0;
  logic [15:0] idle_limit = ExpiryReset;

  frag_in_t  pending_frags[$];
  frag_out_t expected_results[$];
  int unsigned errors = 0;

  initial begin
    for (int s = 0; s < NSLOT; s++) busy_q[s] = 1'b0;
  end

  // Append one item to the pending queue.
  task automatic queue_frag(frag_in_t f);
    pending_frags.insert(pending_frags.size(), f);
  endtask

  // Apply one transaction to the bench table and return the expected result.
  function automatic frag_out_t track_fragment(frag_in_t x);
    frag_out_t r;
    logic [15:0] room, copy;
    logic [7:0] mask;
    r = '0;
    if (x.kind) begin
      mask = '0;
      clock_ms = clock_ms + 32'd1;
      for (int s = 0; s < NSLOT; s++) begin
        if (busy_q[s] && (clock_ms - stamp_q[s]) >= {16'd0, idle_limit}) begin
          busy_q[s] = 1'b0;
          mask[s] = 1'b1;
        end
      end
      r.status = ST_TICK;
      r.expired_mask = mask;
      return r;
    end
    // lowest matching slot takes the fragment; last index 255 never matches
    for (int s = 0; s < NSLOT; s++) begin
      if (busy_q[s] && source_q[s] == x.src_mac && ident_q[s] == x.msg_id &&
          {1'b0, x.frag_index} == {1'b0, last_q[s]} + 9'd1) begin
        room = total_q[s] - filled_q[s];
        copy = ({8'd0, x.frag_len} < room) ? {8'd0, x.frag_len} : room;
        r.slot = s[2:0];
        r.write_offset = filled_q[s];
        r.copy_len = copy[7:0];
        filled_q[s] = filled_q[s] + copy;
        last_q[s] = x.frag_index;
        stamp_q[s] = clock_ms;
        if (filled_q[s] >= total_q[s]) begin
          busy_q[s] = 1'b0;
          r.status = ST_COMPLETED;
          r.done_type = mtype_q[s];
          r.done_size = total_q[s];
        end else begin
          r.status = ST_APPENDED;
        end
        return r;
      end
    end
    if (x.frag_index != 8'd0) begin
      r.status = ST_IGNORED;
      return r;
    end
    // open the lowest free slot, or report it at once if already complete
    for (int s = 0; s < NSLOT; s++) begin
      if (!busy_q[s]) begin
        copy = ({8'd0, x.frag_len} < x.total_size) ? {8'd0, x.frag_len} : x.total_size;
        r.slot = s[2:0];
        r.copy_len = copy[7:0];
        if (copy >= x.total_size) begin
          r.status = ST_COMPLETED;
          r.done_type = x.msg_type;
          r.done_size = x.total_size;
          return r;
        end
        busy_q[s] = 1'b1;
        source_q[s] = x.src_mac;
        ident_q[s] = x.msg_id;
        last_q[s] = 8'd0;
        filled_q[s] = copy;
        total_q[s] = x.total_size;
        mtype_q[s] = x.msg_type;
        stamp_q[s] = clock_ms;
        r.status = ST_STARTED;
        return r;
      end
    end
    r.status = ST_FULL;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pop pending fragments, idle a random number of cycles per item
  // --------------------------------------------------------------------------
  int unsigned tx_gap = 0;
  logic        in_take;

  assign in_take = in_valid && !in_stall;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_take) expected_results.insert(expected_results.size(), track_fragment(in_data));
      // hold a stalled transaction unchanged
      if (!(in_valid && in_stall)) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_frags.size() != 0) begin
          in_data <= pending_frags.pop_front();
          in_valid <= 1'b1;
          // about a third of the items come with a gap, the rest back to back
          tx_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: one stretch in the middle of the run lets the sender back
  // up into the block
  // --------------------------------------------------------------------------
  int unsigned hold_clock = 0;
  int unsigned long_hold = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_clock <= 0;
      long_hold <= 0;
    end else begin
      hold_clock <= hold_clock + 1;
      if (hold_clock == HOLD_START) long_hold <= HOLD_LEN;
      else if (long_hold != 0) long_hold <= long_hold - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and receiver: compare, then draw the next stall
  // --------------------------------------------------------------------------
  int unsigned rx_wait = 0;
  logic        out_take;

  assign out_take = out_valid && !out_stall;

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    frag_out_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_take) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding: status %0d", out_data.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", exp_r.status, out_data.status);
          check_field("slot", exp_r.slot, out_data.slot);
          check_field("write_offset", exp_r.write_offset, out_data.write_offset);
          check_field("copy_len", exp_r.copy_len, out_data.copy_len);
          check_field("done_type", exp_r.done_type, out_data.done_type);
          check_field("done_size", exp_r.done_size, out_data.done_size);
          check_field("expired_mask", exp_r.expired_mask, out_data.expired_mask);
        end
        rx_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (long_hold != 0) || (rx_wait != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no transaction on either channel
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (in_take || out_take || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_MAX) begin
      $display("FAIL fragment_reassembly_tracker_top");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic frag_in_t frag(logic [47:0] mac, logic [15:0] id, logic [7:0] idx,
                                    logic [7:0] len, logic [7:0] mt, logic [15:0] tot);
    frag_in_t f;
    f.kind = 1'b0;
    f.src_mac = mac;
    f.msg_id = id;
    f.frag_index = idx;
    f.frag_len = len;
    f.msg_type = mt;
    f.total_size = tot;
    return f;
  endfunction

  function automatic frag_in_t noise_item();
    frag_in_t f;
    f = frag_in_t'($bits(frag_in_t)'({$urandom, $urandom, $urandom, $urandom}));
    return f;
  endfunction

  function automatic frag_in_t tick_item();
    frag_in_t f;
    f = noise_item();  // only kind matters on a tick
    f.kind = 1'b1;
    return f;
  endfunction

  // Wait for the block to drain, then write expiry_ms.
  task automatic drain_and_set(logic [15:0] v);
    while (pending_frags.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    idle_limit = v;
  endtask

  // Interleaved messages from a few senders, mostly well-formed, with ticks and noise.
  task automatic random_phase(int unsigned n);
    logic [47:0] mac [NSTREAM];
    logic [15:0] id [NSTREAM];
    logic [7:0]  nxt [NSTREAM];
    logic [15:0] tot [NSTREAM];
    logic [7:0]  mt [NSTREAM];
    int unsigned k, pick;
    for (int i = 0; i < NSTREAM; i++) begin
      mac[i] = {16'($urandom), $urandom};
      id[i] = 16'($urandom);
      nxt[i] = 8'd0;
      tot[i] = 16'($urandom_range(0, 700));
      mt[i] = 8'($urandom);
    end
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        k = $urandom_range(0, NSTREAM - 1);
        if (nxt[k] == 8'd0 || $urandom_range(0, 9) == 0) begin
          // restart the stream with a new message, sometimes a new id
          if ($urandom_range(0, 1) == 0) id[k] = 16'($urandom);
          tot[k] = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 700));
          mt[k] = 8'($urandom);
          nxt[k] = 8'd0;
        end
        queue_frag(frag(mac[k], id[k],
                        ($urandom_range(0, 19) == 0) ? nxt[k] + 8'd1 : nxt[k],
                        8'($urandom), mt[k], tot[k]));
        nxt[k]++;
      end else if (pick < 85) begin
        queue_frag(tick_item());
      end else begin
        queue_frag(noise_item());
      end
    end
  endtask

  initial begin
    logic [47:0] mac_a;
    mac_a = 48'h0000_5a5a_0001;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes and special cases, default expiry
    queue_frag(tick_item());
    queue_frag(frag('1, '1, 8'd0, 8'd0, 8'hff, 16'd0));      // zero size: completes
    queue_frag(frag('0, '0, 8'd0, 8'd255, 8'h00, 16'd200));  // first covers all
    queue_frag(frag('1, '1, 8'd0, 8'd100, 8'ha5, 16'hffff)); // opens slot 0
    queue_frag(frag('1, '1, 8'd0, 8'd10, 8'h5a, 16'd300));   // repeated first: slot 1
    queue_frag(frag('1, '1, 8'd1, 8'd255, 8'h00, 16'd0));    // lowest slot appends
    queue_frag(frag('1, '1, 8'd7, 8'd1, 8'h00, 16'd0));      // no match: ignored
    queue_frag(frag('1, '1, 8'd1, 8'd255, 8'h00, 16'd0));    // slot 1 append
    queue_frag(frag('1, '1, 8'd2, 8'd255, 8'h00, 16'd0));    // lowest slot appends again
    for (int i = 0; i < 8; i++)
      queue_frag(frag(mac_a + 48'(i), 16'd7, 8'd0, 8'd1, 8'd3, 16'd50));
    queue_frag(frag(mac_a, 16'd8, 8'd0, 8'd1, 8'd3, 16'd50)); // table full
    queue_frag(frag(mac_a, 16'd9, 8'd0, 8'd0, 8'd3, 16'd0));  // zero size, full
    drain_and_set(16'd1);
    queue_frag(tick_item());  // frees every slot
    queue_frag(tick_item());

    // drive one message through index 255; the next index does not wrap
    drain_and_set(16'hffff);
    for (int i = 0; i < 256; i++)
      queue_frag(frag(mac_a, 16'h1234, i[7:0], 8'd0, 8'h42, 16'd1000));
    queue_frag(frag(mac_a, 16'h1234, 8'd0, 8'd5, 8'h42, 16'd1000));
    drain_and_set(16'd0);
    queue_frag(tick_item());

    drain_and_set(ExpiryReset);
    random_phase(250);
    drain_and_set(16'd20);
    random_phase(300);
    drain_and_set(16'd3);
    random_phase(250);
    drain_and_set(16'd1);
    random_phase(150);
    drain_and_set(16'hffff);
    random_phase(150);
    drain_and_set(16'd50);
    random_phase(100);

    while (pending_frags.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS fragment_reassembly_tracker_top");
    end else begin
      $display("FAIL fragment_reassembly_tracker_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/frt_pkg.sv
rtl/core/frt_ctrl.sv
rtl/core/frt_dp.sv
rtl/core/fragment_reassembly_tracker_top.sv
rtl/core/frt_checker.sv
test/tb_fragment_reassembly_tracker_top.sv
